### design/wos_pkg.sv
// ----------------------------------------------------------------------------
// wos_pkg
// Shared types, codes and saturation helpers of the wheel odometry sample FIFO.
// ----------------------------------------------------------------------------
package wos_pkg;

   // Default number of FIFO slots; one slot always stays empty
   localparam int FIFO_DEPTH_DEF = 16;

   // Operation codes carried in the request tuser
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Configuration register indexes
   localparam int         CSR_IDX_W       = 2;
   localparam logic [1:0] CSR_SCALE_LEFT  = 2'd0;
   localparam logic [1:0] CSR_SCALE_RIGHT = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd2;

   // Register reset values and limits
   localparam logic signed [31:0] SCALE_RESET = 32'sd107374;
   localparam logic [19:0]        RATE_RESET  = 20'd250;
   localparam logic [19:0]        RATE_MAX    = 20'd999999;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic [19:0]        sample_rate;
      logic signed [31:0] scale_right;
      logic signed [31:0] scale_left;
   } cfg_type;

   // Classified command, left tick already negated
   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] right_tick;
      logic signed [15:0] left_tick;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

   // One FIFO entry, 128 bits
   typedef struct packed {
      logic signed [31:0] mean_speed;
      logic signed [31:0] delta_right;
      logic signed [31:0] delta_left;
      logic signed [15:0] right_tick;
      logic signed [15:0] left_tick;
   } entry_type;

   // Result payload, first field in the lowest bits, padded to whole bytes
   typedef struct packed {
      logic [2:0]         pad;
      logic [3:0]         backlog;
      logic signed [47:0] odom_right;
      logic signed [47:0] odom_left;
      logic signed [31:0] right_speed;
      logic signed [31:0] left_speed;
      logic signed [31:0] mean_speed;
      logic signed [31:0] delta_right;
      logic signed [31:0] delta_left;
      logic signed [15:0] right_tick;
      logic signed [15:0] left_tick;
      logic               ok;
   } rsp_type;

   // Clamp a product-wide value to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
      logic [PROD_W-32:0] hi;
      hi = x[PROD_W-1:31];
      if ((&hi) || !(|hi)) return x[31:0];
      if (x[PROD_W-1]) return 32'sh8000_0000;
      return 32'sh7FFF_FFFF;
   endfunction

   // Clamp a 49-bit sum to 48 bits signed
   function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
      if (x[48] == x[47]) return x[47:0];
      if (x[48]) return 48'sh8000_0000_0000;
      return 48'sh7FFF_FFFF_FFFF;
   endfunction

endpackage

### design/wos_ram.sv
// ----------------------------------------------------------------------------
// wos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wos_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/wos_front.sv
// ----------------------------------------------------------------------------
// wos_front
// Accepts request items and register writes, classifies each item and
// holds it in a two-slot queue for the execution side.
// ----------------------------------------------------------------------------
module wos_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // left_count, right_count
   input  logic [1:0]                     req_tuser,  // operation
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data,
   output wos_pkg::cfg_type               cfg,
   output wos_pkg::queue_type             q_head,
   input  logic                           q_pop
);
   import wos_pkg::*;

   localparam logic [1:0] QUEUE_SLOTS = 2'd2;

   cmd_type    slot_ff [2];
   logic       wr_sel_ff;
   logic       rd_sel_ff;
   logic [1:0] cnt_ff;
   cfg_type    cfg_ff;
   cmd_type    cmd_in;
   logic       push;
   logic [19:0] rate_wr;

   assign req_tready = (cnt_ff != QUEUE_SLOTS);
   assign push       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rate_wr    = csr_data[19:0];

   // Classify: negate left count with 16-bit wrap
   always_comb begin
      cmd_in.op         = req_tuser;
      cmd_in.left_tick  = 16'(-$signed(req_tdata[15:0]));
      cmd_in.right_tick = req_tdata[31:16];
   end

   assign q_head.valid = (cnt_ff != 2'd0);
   assign q_head.cmd   = slot_ff[rd_sel_ff];
   assign cfg          = cfg_ff;

   // Queue bookkeeping and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff          <= 1'b0;
         rd_sel_ff          <= 1'b0;
         cnt_ff             <= 2'd0;
         cfg_ff.scale_left  <= SCALE_RESET;
         cfg_ff.scale_right <= SCALE_RESET;
         cfg_ff.sample_rate <= RATE_RESET;
      end else begin
         if (push) begin
            slot_ff[wr_sel_ff] <= cmd_in;
            wr_sel_ff          <= ~wr_sel_ff;
         end
         if (q_pop) begin
            rd_sel_ff <= ~rd_sel_ff;
         end
         case ({push, q_pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
         // Drop zero scales and out-of-range rates
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SCALE_LEFT: begin
                  if (csr_data != 32'd0) cfg_ff.scale_left <= csr_data;
               end
               CSR_SCALE_RIGHT: begin
                  if (csr_data != 32'd0) cfg_ff.scale_right <= csr_data;
               end
               CSR_SAMPLE_RATE: begin
                  if (rate_wr != 20'd0 && rate_wr <= RATE_MAX) cfg_ff.sample_rate <= rate_wr;
               end
               default: ;
            endcase
         end
      end
   end

endmodule

### design/wos_back.sv
// ----------------------------------------------------------------------------
// wos_back
// Executes queued commands: scales ticks and forms speeds on one shared
// multiplier, keeps odometry and the sample ring FIFO, and registers results.
// ----------------------------------------------------------------------------
module wos_back #(
   parameter int FIFO_DEPTH = wos_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  wos_pkg::cfg_type   cfg,
   input  wos_pkg::queue_type q_head,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [295:0]       rsp_tdata,
   output logic [1:0]         rsp_tuser
);
   import wos_pkg::*;

   localparam int         PW      = $clog2(FIFO_DEPTH);
   localparam logic [PW:0] DEPTH_W = (PW+1)'(FIFO_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_DL, S_DR, S_SL, S_SA, S_SR, S_DONE, S_POP, S_MISC
   } state_type;

   state_type                 state_ff;
   cmd_type                   cmd_ff;
   logic [PW-1:0]             wp_ff, rp_ff, wp_nx, rp_nx;
   logic signed [47:0]        odl_ff, odr_ff, odl_in, odr_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [32:0]        dsum;
   logic signed [31:0]        dl_ff, dr_ff, sl_ff, sa_ff;
   rsp_type                   rsp_ff, rsp_in;
   logic [1:0]                kind_ff;
   logic                      rsp_valid_ff;
   logic                      out_free, full, empty, commit, ram_wr_en;
   logic [PW:0]               count_nx;
   entry_type                 wr_entry, rd_entry;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      if (p == PW'(FIFO_DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = (ptr_next(wp_ff) == rp_ff);
   assign empty    = (wp_ff == rp_ff);
   assign commit   = out_free &&
                     (state_ff == S_DONE || state_ff == S_POP || state_ff == S_MISC);
   assign q_pop    = (state_ff == S_IDLE) && q_head.valid;
   assign dsum     = {dl_ff[31], dl_ff} + {dr_ff[31], dr_ff};

   // Select operands of the shared multiplier per step
   always_comb begin
      mul_a = '0;
      mul_b = {12'd0, cfg.sample_rate};
      case (state_ff)
         S_DL: begin
            mul_a = {{17{cmd_ff.left_tick[15]}}, cmd_ff.left_tick};
            mul_b = cfg.scale_left;
         end
         S_DR: begin
            mul_a = {{17{cmd_ff.right_tick[15]}}, cmd_ff.right_tick};
            mul_b = cfg.scale_right;
         end
         S_SL:    mul_a = {dl_ff[31], dl_ff};
         S_SA:    mul_a = dsum;
         S_SR:    mul_a = {dr_ff[31], dr_ff};
         default: mul_a = '0;
      endcase
      prod_in = mul_a * mul_b;
   end

   // Pointer update and backlog after the step
   always_comb begin
      wp_nx = ((state_ff == S_DONE) && !full)  ? ptr_next(wp_ff) : wp_ff;
      rp_nx = ((state_ff == S_POP)  && !empty) ? ptr_next(rp_ff) : rp_ff;
      if (wp_nx >= rp_nx) count_nx = {1'b0, wp_nx} - {1'b0, rp_nx};
      else                count_nx = {1'b0, wp_nx} + DEPTH_W - {1'b0, rp_nx};
   end

   // Build the result and the next odometry
   always_comb begin
      odl_in = odl_ff;
      odr_in = odr_ff;
      rsp_in = '0;
      case (state_ff)
         S_DONE: begin
            odl_in             = sat48({odl_ff[47], odl_ff} + {{17{dl_ff[31]}}, dl_ff});
            odr_in             = sat48({odr_ff[47], odr_ff} + {{17{dr_ff[31]}}, dr_ff});
            rsp_in.ok          = !full;
            rsp_in.left_tick   = cmd_ff.left_tick;
            rsp_in.right_tick  = cmd_ff.right_tick;
            rsp_in.delta_left  = dl_ff;
            rsp_in.delta_right = dr_ff;
            rsp_in.mean_speed  = sa_ff;
            rsp_in.left_speed  = sl_ff;
            rsp_in.right_speed = sat32(prod_ff);
         end
         S_POP: begin
            if (!empty) begin
               rsp_in.ok          = 1'b1;
               rsp_in.left_tick   = rd_entry.left_tick;
               rsp_in.right_tick  = rd_entry.right_tick;
               rsp_in.delta_left  = rd_entry.delta_left;
               rsp_in.delta_right = rd_entry.delta_right;
               rsp_in.mean_speed  = rd_entry.mean_speed;
            end
         end
         S_MISC: begin
            if (cmd_ff.op == OP_CLEAR) begin
               odl_in    = '0;
               odr_in    = '0;
               rsp_in.ok = 1'b1;
            end
         end
         default: ;
      endcase
      rsp_in.odom_left  = odl_in;
      rsp_in.odom_right = odr_in;
      rsp_in.backlog    = 4'(count_nx);
   end

   // Sample store
   assign ram_wr_en = (state_ff == S_DONE) && out_free && !full;

   always_comb begin
      wr_entry.left_tick   = cmd_ff.left_tick;
      wr_entry.right_tick  = cmd_ff.right_tick;
      wr_entry.delta_left  = dl_ff;
      wr_entry.delta_right = dr_ff;
      wr_entry.mean_speed  = sa_ff;
   end

   wos_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_entry),
      .rd_addr (rp_ff),
      .rd_data (rd_entry)
   );

   // Sequencer, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         odl_ff       <= '0;
         odr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Hold the right speed product while the result waits
         if (state_ff != S_DONE) prod_ff <= prod_in;
         if (rsp_valid_ff && rsp_tready && !commit) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_head.valid) begin
                  cmd_ff <= q_head.cmd;
                  unique case (q_head.cmd.op)
                     OP_SAMPLE: state_ff <= S_DL;
                     OP_POP:    state_ff <= S_POP;
                     default:   state_ff <= S_MISC;
                  endcase
               end
            end
            S_DL: state_ff <= S_DR;
            S_DR: begin
               dl_ff    <= sat32(prod_ff >>> 6);
               state_ff <= S_SL;
            end
            S_SL: begin
               dr_ff    <= sat32(prod_ff >>> 6);
               state_ff <= S_SA;
            end
            S_SA: begin
               sl_ff    <= sat32(prod_ff);
               state_ff <= S_SR;
            end
            S_SR: begin
               sa_ff    <= sat32(prod_ff >>> 1);
               state_ff <= S_DONE;
            end
            S_DONE, S_POP, S_MISC: begin
               if (commit) begin
                  wp_ff        <= wp_nx;
                  rp_ff        <= rp_nx;
                  odl_ff       <= odl_in;
                  odr_ff       <= odr_in;
                  rsp_ff       <= rsp_in;
                  kind_ff      <= cmd_ff.op;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = kind_ff;

   // Pointers never leave the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PW'(FIFO_DEPTH - 1) && rp_ff <= PW'(FIFO_DEPTH - 1))
      else $error("FIFO pointer out of range");

   // Multiply chain runs without gaps
   a_mul_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DL |=> state_ff == S_DR)
      else $error("multiply sequence broken");

   // A stored sample leaves the FIFO non-empty
   a_store_nonempty: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> wp_ff != rp_ff)
      else $error("store write left FIFO empty");

   // A clear reports zero odometry
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      commit && state_ff == S_MISC && cmd_ff.op == OP_CLEAR
      |=> rsp_valid_ff && rsp_ff.odom_left == '0 && rsp_ff.odom_right == '0)
      else $error("clear did not zero odometry");

   // A pop of a non-empty FIFO advances the read pointer
   a_pop_advance: assert property (@(posedge clock) disable iff (reset)
      commit && state_ff == S_POP && wp_ff != rp_ff |=> rp_ff != $past(rp_ff))
      else $error("pop did not advance read pointer");

endmodule

### design/wheel_odometry_sample_fifo.sv
// Sequence: a sample steps S_DL, S_DR, S_SL, S_SA, S_SR on the single 33x32 multiplier used
// five times, then S_DONE; pop, clear and other codes use S_POP or S_MISC. Each result waits
// for a free output before the next item starts. A two-slot queue keeps the request side open.
// Reset: synchronous, active high; clears pointers, odometry, queue and output valid,
// and loads the register defaults. The sample store itself is not cleared.
// ----------------------------------------------------------------------------
// wheel_odometry_sample_fifo
// Wheel tick scaling, speed and odometry with a ring FIFO of past samples.
// ----------------------------------------------------------------------------
module wheel_odometry_sample_fifo #(
   parameter int FIFO_DEPTH = wos_pkg::FIFO_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // left_count, right_count
   input  logic [1:0]                    req_tuser,   // operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // ok, left_tick, right_tick, delta_left, delta_right, mean_speed,
   // left_speed, right_speed, odom_left, odom_right, backlog, zero pad
   output logic [295:0]                  rsp_tdata,
   output logic [1:0]                    rsp_tuser,   // kind
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wos_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import wos_pkg::*;

   cfg_type   cfg;
   queue_type q_head;
   logic      q_pop;

   wos_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   wos_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
